// ===== sv/tsts_pkg.sv =====
// ============================================================================
// tsts_pkg: time slice task scheduler shared definitions
// Sizes, field codes, register indexes and controller states.
// ============================================================================
`default_nettype none

package tsts_pkg;

    // Table geometry
    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 16;
    localparam int ID_W      = 8;
    localparam int ADDR_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int WORD_W    = ID_W + TIME_BITS;

    // Port widths
    localparam int BURST_W = 16;
    localparam int REM_W   = 16;
    localparam int CFG_W   = 8;

    // Register reset values
    localparam logic [CFG_W-1:0] SLICE_RESET = 8'd2;

    // Item kinds
    localparam logic KIND_ADD      = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    // Scheduling modes
    localparam logic MODE_FCFS = 1'b0;
    localparam logic MODE_SPF  = 1'b1;

    // Configuration register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_SLICE = 1'b1;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [ID_W-1:0]      id_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_SHIFT,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/tsts_ram.sv =====
// ============================================================================
// tsts_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module tsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/time_slice_task_scheduler_top.sv =====
// ============================================================================
// time_slice_task_scheduler_top: round robin / shortest remaining scheduler
// Task table held in one RAM in queue order, served by a sequencer.
// ============================================================================
// One item is worked at a time; the input stalls until its result has been
// moved to the output register. An add writes its entry at the tail, or flags
// a full table, then hands its result over. A dispatch scans the table
// through the single RAM read port (one entry in first come first served
// mode, all N entries in shortest remaining mode, N being the number of
// queued tasks), then closes the gap left by the picked task by copying the
// entries behind it down one slot, one per cycle, and appends the task at
// the tail if time is left. A stalled output delays the handoff. The RAM
// read port is what bounds the scan and the copy. No clearing pass is needed
// after reset.
`default_nettype none

module time_slice_task_scheduler_top
    import tsts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic [BURST_W-1:0] burst_time,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [ID_W-1:0]         task_id,
    output logic                    granted,
    output logic                    finished,
    output logic [REM_W-1:0]        remaining,
    output logic                    full_res
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t             state_reg,     state_next;
    logic               mode_reg;
    logic [CFG_W-1:0]   slice_reg;
    logic [CNT_W-1:0]   count_reg,     count_next;
    id_t                next_id_reg,   next_id_next;
    id_t                last_id_reg,   last_id_next;
    logic               last_valid_reg, last_valid_next;

    logic [CNT_W-1:0]   rd_idx_reg,    rd_idx_next;
    logic               pend_reg,      pend_next;
    logic [ADDR_W-1:0]  pend_pos_reg,  pend_pos_next;

    // best candidate skipping the last run task, and best over all
    logic               bs_found_reg,  bs_found_next;
    logic [ADDR_W-1:0]  bs_pos_reg,    bs_pos_next;
    id_t                bs_id_reg,     bs_id_next;
    time_t              bs_time_reg,   bs_time_next;
    logic               ba_found_reg,  ba_found_next;
    logic [ADDR_W-1:0]  ba_pos_reg,    ba_pos_next;
    id_t                ba_id_reg,     ba_id_next;
    time_t              ba_time_reg,   ba_time_next;

    // picked task after its slice
    id_t                sel_id_reg,    sel_id_next;
    time_t              sel_time_reg,  sel_time_next;

    // pending result
    id_t                res_id_reg,    res_id_next;
    logic               res_grant_reg, res_grant_next;
    logic               res_fin_reg,   res_fin_next;
    time_t              res_rem_reg,   res_rem_next;
    logic               res_full_reg,  res_full_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    id_t                out_id_reg;
    logic               out_grant_reg;
    logic               out_fin_reg;
    logic [REM_W-1:0]   out_rem_reg;
    logic               out_full_reg;

    // ------------------------------------------------------------------
    // Task table RAM: {id, time left}
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    tsts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    id_t   r_id;
    time_t r_time;
    logic  r_skip;
    logic  in_accept;
    logic  rd_issue;
    logic [CNT_W-1:0] scan_limit;
    logic  pick_bs;
    time_t pick_time;
    time_t slice_t;

    assign r_id      = ram_rdata[WORD_W-1:TIME_BITS];
    assign r_time    = ram_rdata[TIME_BITS-1:0];
    assign r_skip    = last_valid_reg && (r_id == last_id_reg);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign scan_limit = (mode_reg == MODE_FCFS) ? CNT_W'(1) : count_reg;
    assign pick_bs   = bs_found_reg;
    assign pick_time = pick_bs ? bs_time_reg : ba_time_reg;
    assign slice_t   = TIME_BITS'(slice_reg);
    assign ram_raddr = rd_idx_reg[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer: next state, table access and result
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        last_id_next    = last_id_reg;
        last_valid_next = last_valid_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = 1'b0;
        pend_pos_next   = pend_pos_reg;
        bs_found_next   = bs_found_reg;
        bs_pos_next     = bs_pos_reg;
        bs_id_next      = bs_id_reg;
        bs_time_next    = bs_time_reg;
        ba_found_next   = ba_found_reg;
        ba_pos_next     = ba_pos_reg;
        ba_id_next      = ba_id_reg;
        ba_time_next    = ba_time_reg;
        sel_id_next     = sel_id_reg;
        sel_time_next   = sel_time_reg;
        res_id_next     = res_id_reg;
        res_grant_next  = res_grant_reg;
        res_fin_next    = res_fin_reg;
        res_rem_next    = res_rem_reg;
        res_full_next   = res_full_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[ADDR_W-1:0];
        ram_wdata       = {next_id_reg, TIME_BITS'(burst_time)};
        rd_issue        = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_id_next    = '0;
                    res_grant_next = 1'b0;
                    res_fin_next   = 1'b0;
                    res_rem_next   = '0;
                    res_full_next  = 1'b0;
                    if (kind == KIND_ADD)
                    begin
                        // append at the tail, or flag full
                        if (count_reg == CNT_W'(MAX_PROCS))
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            res_id_next  = next_id_reg;
                            count_next   = count_reg + CNT_W'(1);
                            next_id_next = next_id_reg + ID_W'(1);
                        end
                        state_next = ST_RESULT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        rd_idx_next   = '0;
                        bs_found_next = 1'b0;
                        ba_found_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue reads over the candidate range
                if (rd_idx_reg < scan_limit)
                begin
                    rd_issue      = 1'b1;
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_pos_next = rd_idx_reg[ADDR_W-1:0];
                end
                // compare the entry that came back
                if (pend_reg)
                begin
                    if (!r_skip && (!bs_found_reg || r_time < bs_time_reg))
                    begin
                        bs_found_next = 1'b1;
                        bs_pos_next   = pend_pos_reg;
                        bs_id_next    = r_id;
                        bs_time_next  = r_time;
                    end
                    if (!ba_found_reg || r_time < ba_time_reg)
                    begin
                        ba_found_next = 1'b1;
                        ba_pos_next   = pend_pos_reg;
                        ba_id_next    = r_id;
                        ba_time_next  = r_time;
                    end
                end
                if (!rd_issue && !pend_reg)
                begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                // run the picked task for one slice, drop it from the queue
                sel_id_next   = pick_bs ? bs_id_reg : ba_id_reg;
                sel_time_next = (pick_time > slice_t) ? (pick_time - slice_t) : '0;
                rd_idx_next   = CNT_W'(pick_bs ? bs_pos_reg : ba_pos_reg) + CNT_W'(1);
                count_next    = count_reg - CNT_W'(1);
                state_next    = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                // copy entries behind the gap down one slot
                if (rd_idx_reg <= count_reg)
                begin
                    rd_issue      = 1'b1;
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_pos_next = rd_idx_reg[ADDR_W-1:0];
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_pos_reg - ADDR_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (!rd_issue && !pend_reg)
                begin
                    // requeue at the tail or retire
                    res_id_next    = sel_id_reg;
                    res_grant_next = 1'b1;
                    res_rem_next   = sel_time_reg;
                    if (sel_time_reg != '0)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = count_reg[ADDR_W-1:0];
                        ram_wdata       = {sel_id_reg, sel_time_reg};
                        count_next      = count_reg + CNT_W'(1);
                        last_id_next    = sel_id_reg;
                        last_valid_next = 1'b1;
                        res_fin_next    = 1'b0;
                    end
                    else
                    begin
                        last_valid_next = 1'b0;
                        res_fin_next    = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_FCFS;
            slice_reg      <= SLICE_RESET;
            count_reg      <= '0;
            next_id_reg    <= '0;
            last_id_reg    <= '0;
            last_valid_reg <= 1'b0;
            rd_idx_reg     <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            last_id_reg    <= last_id_next;
            last_valid_reg <= last_valid_next;
            rd_idx_reg     <= rd_idx_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:  mode_reg  <= cfg_data[0];
                    REG_SLICE: slice_reg <= cfg_data;
                    default:   mode_reg  <= mode_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        pend_pos_reg  <= pend_pos_next;
        bs_found_reg  <= bs_found_next;
        bs_pos_reg    <= bs_pos_next;
        bs_id_reg     <= bs_id_next;
        bs_time_reg   <= bs_time_next;
        ba_found_reg  <= ba_found_next;
        ba_pos_reg    <= ba_pos_next;
        ba_id_reg     <= ba_id_next;
        ba_time_reg   <= ba_time_next;
        sel_id_reg    <= sel_id_next;
        sel_time_reg  <= sel_time_next;
        res_id_reg    <= res_id_next;
        res_grant_reg <= res_grant_next;
        res_fin_reg   <= res_fin_next;
        res_rem_reg   <= res_rem_next;
        res_full_reg  <= res_full_next;
        if (out_load)
        begin
            out_id_reg    <= res_id_reg;
            out_grant_reg <= res_grant_reg;
            out_fin_reg   <= res_fin_reg;
            out_rem_reg   <= REM_W'(res_rem_reg);
            out_full_reg  <= res_full_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign task_id   = out_id_reg;
    assign granted   = out_grant_reg;
    assign finished  = out_fin_reg;
    assign remaining = out_rem_reg;
    assign full_res  = out_full_reg;

`ifndef ASSERT_OFF
    // the queue never holds more tasks than the table has slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROCS))
        else $error("task count beyond table size");

    // a shift copy never targets a slot below the table start
    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && pend_reg) |-> (pend_pos_reg != '0))
        else $error("shift copy from slot zero");

    // a retired task must have been granted, and a full flag grants nothing
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!(out_fin_reg && !out_grant_reg) &&
                           !(out_full_reg && out_grant_reg)))
        else $error("inconsistent result flags");

    // a result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(out_id_reg) && $stable(out_rem_reg)))
        else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: time slice task scheduler check
// Drives add and dispatch items through the scheduler under random idling on
// both channels, tracks the task table alongside it, and compares every
// result item with the one worked out for it.
// ============================================================================

module testbench;
    import tsts_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 95;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * MAX_PROCS + 16;
    localparam int SLICE_DRAW  = -1;

    typedef struct packed {
        id_t              task_id;
        logic             granted;
        logic             finished;
        logic [REM_W-1:0] remaining;
        logic             full_res;
    } sched_reply_t;

    typedef enum logic {ROW_ITEM, ROW_CONFIG} row_op_t;

    typedef struct packed {
        row_op_t            op;
        logic               kind;
        logic [BURST_W-1:0] burst;
        logic               mode_val;
        logic [CFG_W-1:0]   slice_val;
        logic               fixed;
        sched_reply_t       want;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = REG_MODE;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = KIND_ADD;
    logic [BURST_W-1:0] burst_time = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    id_t                task_id;
    logic               granted;
    logic               finished;
    logic [REM_W-1:0]   remaining;
    logic               full_res;

    time_slice_task_scheduler_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .burst_time (burst_time),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .task_id    (task_id),
        .granted    (granted),
        .finished   (finished),
        .remaining  (remaining),
        .full_res   (full_res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow task table, kept in queue order
    id_t              tbl_id   [MAX_PROCS];
    time_t            tbl_left [MAX_PROCS];
    int               tbl_count = 0;
    id_t              id_next = '0;
    id_t              prev_id = '0;
    logic             prev_valid = 1'b0;
    logic             cur_mode = MODE_FCFS;
    logic [CFG_W-1:0] cur_slice = SLICE_RESET;

    sched_reply_t replies_due [$];
    script_row_t  script [$];
    int           mismatches = 0;
    bit           calm = 1'b0;
    int           hold_out = 0;
    int           quiet_cycles = 0;
    sched_reply_t seen;
    sched_reply_t owed;

    function automatic int pause_len();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    // Position of the shortest task, ties to the earlier slot; -1 if none
    function automatic int find_shortest(logic skip_prev);
        int best;
        best = -1;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (skip_prev && tbl_id[i] == prev_id)
                continue;
            if (best < 0 || tbl_left[i] < tbl_left[best])
                best = i;
        end
        return best;
    endfunction

    // Apply one item to the shadow table and return the reply it causes
    function automatic sched_reply_t step_table(logic k, logic [BURST_W-1:0] b);
        sched_reply_t r;
        int           pos;
        id_t          id;
        time_t        left;
        r = '0;
        if (k == KIND_ADD)
        begin
            if (tbl_count >= MAX_PROCS)
                r.full_res = 1'b1;
            else
            begin
                tbl_id[tbl_count]   = id_next;
                tbl_left[tbl_count] = b[TIME_BITS-1:0];
                tbl_count++;
                r.task_id = id_next;
                id_next   = id_next + 1'b1;
            end
            return r;
        end
        if (tbl_count == 0)
            return r;
        if (cur_mode == MODE_FCFS)
            pos = 0;
        else
        begin
            pos = find_shortest(prev_valid);
            if (pos < 0)
                pos = find_shortest(1'b0);
        end
        id   = tbl_id[pos];
        left = (tbl_left[pos] > cur_slice) ? tbl_left[pos] - cur_slice : '0;
        // close the gap behind the picked task
        for (int i = pos; i + 1 < tbl_count; i++)
        begin
            tbl_id[i]   = tbl_id[i + 1];
            tbl_left[i] = tbl_left[i + 1];
        end
        tbl_count--;
        r.task_id   = id;
        r.granted   = 1'b1;
        r.remaining = left;
        if (left != 0)
        begin
            tbl_id[tbl_count]   = id;
            tbl_left[tbl_count] = left;
            tbl_count++;
            prev_id    = id;
            prev_valid = 1'b1;
        end
        else
        begin
            r.finished = 1'b1;
            prev_valid = 1'b0;
        end
        return r;
    endfunction

    function automatic sched_reply_t reply(id_t id, logic g, logic f,
                                           logic [REM_W-1:0] rem, logic full);
        sched_reply_t r;
        r = {id, g, f, rem, full};
        return r;
    endfunction

    function automatic script_row_t item_row(logic k, logic [BURST_W-1:0] b);
        script_row_t row;
        row       = '0;
        row.op    = ROW_ITEM;
        row.kind  = k;
        row.burst = b;
        return row;
    endfunction

    function automatic script_row_t known_row(logic k, logic [BURST_W-1:0] b,
                                              sched_reply_t want);
        script_row_t row;
        row       = item_row(k, b);
        row.fixed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic script_row_t cfg_row(logic m, logic [CFG_W-1:0] s);
        script_row_t row;
        row           = '0;
        row.op        = ROW_CONFIG;
        row.mode_val  = m;
        row.slice_val = s;
        return row;
    endfunction

    function automatic logic [BURST_W-1:0] draw_burst();
        logic [BURST_W-1:0] b;
        int                 span;
        span = 3 * cur_slice + 1;
        case ($urandom_range(0, 9))
            0: b = '0;
            1: b = '1;
            2: b = BURST_W'($urandom);
            default: b = BURST_W'($urandom_range(1, span));
        endcase
        return b;
    endfunction

    task automatic flag(string what, sched_reply_t want, sched_reply_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s: expected id=%0d granted=%0d finished=%0d rem=%0d full=%0d,",
                     $time, what, want.task_id, want.granted, want.finished,
                     want.remaining, want.full_res);
            $display("    got id=%0d granted=%0d finished=%0d rem=%0d full=%0d",
                     got.task_id, got.granted, got.finished, got.remaining,
                     got.full_res);
        end
    endtask

    task automatic drain();
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Send one item after a random gap; hold it until the scheduler takes it
    task automatic push_item(logic k, logic [BURST_W-1:0] b, logic fixed,
                             sched_reply_t want);
        int           gap;
        sched_reply_t worked;
        gap = pause_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        burst_time <= b;
        do
            @(posedge clk);
        while (in_stall);
        worked = step_table(k, b);
        replies_due.push_back(fixed ? want : worked);
    endtask

    // Write both registers once the scheduler has gone idle
    task automatic apply_config(logic m, logic [CFG_W-1:0] s);
        in_valid <= 1'b0;
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= {{(CFG_W-1){1'b0}}, m};
        @(posedge clk);
        cfg_index <= REG_SLICE;
        cfg_data  <= s;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = m;
        cur_slice = s;
    endtask

    // Check each result item against the oldest one owed; draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = {task_id, granted, finished, remaining, full_res};
                if (replies_due.size() == 0)
                    flag("result with nothing owed", '0, seen);
                else
                begin
                    owed = replies_due.pop_front();
                    if (seen !== owed)
                        flag("result differs", owed, seen);
                end
                hold_out = pause_len();
                if (hold_out > 0)
                    out_stall <= 1'b1;
            end
            else if (out_stall)
            begin
                hold_out--;
                if (hold_out == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    logic [BURST_W-1:0] fill_bursts [MAX_PROCS] = '{
        16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h8000, 16'h7FFF,
        16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0004, 16'h0005, 16'h0006,
        16'h0007, 16'h0002
    };
    logic phase_mode [PHASES] = '{
        MODE_SPF, MODE_FCFS, MODE_SPF, MODE_FCFS, MODE_SPF, MODE_SPF,
        MODE_FCFS, MODE_SPF, MODE_FCFS, MODE_SPF, MODE_FCFS, MODE_SPF
    };
    int phase_slice [PHASES] = '{
        1, 255, 0, 1, 255, SLICE_DRAW, SLICE_DRAW, 2, 0, SLICE_DRAW, 2, 1
    };
    int add_share [4] = '{50, 70, 35, 60};

    initial
    begin
        logic [CFG_W-1:0] slice;
        int               add_pct;

        // Directed part: empty table, full table, reset slice, slice extremes
        script.push_back(known_row(KIND_DISPATCH, '0, reply(0, 0, 0, 0, 0)));
        for (int i = 0; i < MAX_PROCS; i++)
            script.push_back(known_row(KIND_ADD, fill_bursts[i],
                                       reply(ID_W'(i), 0, 0, 0, 0)));
        script.push_back(known_row(KIND_ADD, 16'h1234, reply(0, 0, 0, 0, 1)));
        script.push_back(known_row(KIND_DISPATCH, '1, reply(0, 1, 0, 16'hFFFD, 0)));
        script.push_back(known_row(KIND_DISPATCH, '0, reply(1, 1, 1, 0, 0)));
        script.push_back(cfg_row(MODE_SPF, 8'd255));
        repeat (3) script.push_back(item_row(KIND_DISPATCH, 16'h5A5A));
        script.push_back(cfg_row(MODE_SPF, 8'd0));
        repeat (2) script.push_back(item_row(KIND_DISPATCH, 16'hA5A5));
        script.push_back(cfg_row(MODE_SPF, 8'd1));
        repeat (2) script.push_back(item_row(KIND_DISPATCH, '0));
        script.push_back(item_row(KIND_ADD, 16'h0001));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].op == ROW_CONFIG)
                apply_config(script[i].mode_val, script[i].slice_val);
            else
                push_item(script[i].kind, script[i].burst, script[i].fixed,
                          script[i].want);
        end

        // Random phases, each under its own setting; every fourth runs gapless
        for (int p = 0; p < PHASES; p++)
        begin
            if (phase_slice[p] == SLICE_DRAW)
                slice = CFG_W'($urandom_range(1, 254));
            else
                slice = CFG_W'(phase_slice[p]);
            apply_config(phase_mode[p], slice);
            calm    = (p % 4 == 3);
            add_pct = add_share[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_item(($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_DISPATCH,
                          draw_burst(), 1'b0, '0);
        end
        calm = 1'b0;

        // Let the last results arrive, then watch for strays
        in_valid <= 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
